FILE: design/metric_distance_topk_select_unit_assert.svh
// Assertion macros shared by the checker of the top-k selection unit.
// Depends on nothing; include by bare file name.
`ifndef METRIC_DISTANCE_TOPK_SELECT_UNIT_ASSERT_SVH
`define METRIC_DISTANCE_TOPK_SELECT_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MDTS_ASSERT_NOW(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("mdts check failed");

// next-cycle implication, disabled during reset
`define MDTS_ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("mdts check failed");

`endif

FILE: design/mdts_pkg.sv
// Shared types, register codes and helper functions of the top-k selection unit.
// Depends on nothing.
package mdts_pkg;

  localparam logic [2:0] REG_METRIC = 3'd0;
  localparam logic [2:0] REG_MODE   = 3'd1;
  localparam logic [2:0] REG_K      = 3'd2;
  localparam logic [2:0] REG_QNORM  = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;

  localparam logic [1:0] MET_L2  = 2'd0;
  localparam logic [1:0] MET_IP  = 2'd1;
  localparam logic [1:0] MET_COS = 2'd2;

  localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

  typedef struct packed {
    logic [1:0]         metric;
    logic               search_mode;
    logic [4:0]         k_limit;
    logic [31:0]        query_norm;
    logic signed [63:0] radius;
  } cfg_t;

  typedef struct packed {
    logic signed [63:0] distance;
    logic [31:0]        pos;
    logic [63:0]        id;
    logic               del;
    logic               last;
  } rec_t;

  typedef struct packed {
    logic               found;
    logic [63:0]        id;
    logic signed [63:0] distance;
    logic               done;
  } res_t;

  function automatic logic pair_lt(input logic signed [63:0] da, input logic [31:0] pa,
                                   input logic signed [63:0] db, input logic [31:0] pb);
    if (da != db) begin
      return da < db;
    end
    return pa < pb;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [81:0] a);
    if (a > 82'sh7FFF_FFFF_FFFF_FFFF) begin
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    if (a < -82'sh8000_0000_0000_0000) begin
      return 64'sh8000_0000_0000_0000;
    end
    return a[63:0];
  endfunction

endpackage

FILE: design/metric_distance_topk_select_unit.sv
// Front stage holds one candidate at a time and takes the next only after pushing the last;
// cosine runs an 80-step divider, skipped when the denominator is zero.
// Back stage adds a scan of held entries per replacement and one scan per result emitted
// at a top-k scan end.
// Reset: synchronous, active high; clears control, counts and config; held entries stay.
module metric_distance_topk_select_unit
  import mdts_pkg::*;
#(
  parameter int K_MAX = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [63:0]        wr_data,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] est_inner_product,
  input  logic [31:0]        vector_norm,
  input  logic [63:0]        vector_id,
  input  logic               is_deleted,
  input  logic               end_of_scan,
  output logic               empty,
  input  logic               pop,
  output logic               found,
  output logic [63:0]        hit_id,
  output logic signed [63:0] hit_distance,
  output logic               query_done
);
  cfg_t cfg;
  rec_t rec_in;
  rec_t rec_out;
  res_t res_in;
  res_t res_out;
  logic rec_push;
  logic rec_full;
  logic rec_pop;
  logic rec_empty;
  logic res_push;
  logic res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.metric      <= MET_L2;
      cfg.search_mode <= 1'b0;
      cfg.k_limit     <= 5'd1;
      cfg.query_norm  <= '0;
      cfg.radius      <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_METRIC: cfg.metric      <= wr_data[1:0];
        REG_MODE:   cfg.search_mode <= wr_data[0];
        REG_K:      cfg.k_limit     <= wr_data[4:0];
        REG_QNORM:  cfg.query_norm  <= wr_data[31:0];
        REG_RADIUS: cfg.radius      <= wr_data;
        default: begin
        end
      endcase
    end
  end

  mdts_dist u_dist (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .push              (push),
    .full              (full),
    .est_inner_product (est_inner_product),
    .vector_norm       (vector_norm),
    .vector_id         (vector_id),
    .is_deleted        (is_deleted),
    .end_of_scan       (end_of_scan),
    .rec_full          (rec_full),
    .rec_push          (rec_push),
    .rec               (rec_in)
  );

  mdts_fifo #(.W($bits(rec_t)), .DEPTH(2)) u_rec_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .wdata (rec_in),
    .full  (rec_full),
    .pop   (rec_pop),
    .rdata (rec_out),
    .empty (rec_empty)
  );

  mdts_sel #(.K_MAX(K_MAX)) u_sel (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_empty (rec_empty),
    .rec       (rec_out),
    .rec_pop   (rec_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  mdts_fifo #(.W($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign found        = res_out.found;
  assign hit_id       = res_out.id;
  assign hit_distance = res_out.distance;
  assign query_done   = res_out.done;

endmodule

FILE: design/mdts_fifo.sv
// Small register queue used between the stages and at the result port.
// Depends on nothing.
module mdts_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full    = (fill == NW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

FILE: design/mdts_dist.sv
// Front stage: accepts candidates, counts positions and computes the distance.
// Depends on mdts_pkg; one shared multiplier and a radix-2 divider.
module mdts_dist
  import mdts_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] est_inner_product,
  input  logic [31:0]        vector_norm,
  input  logic [63:0]        vector_id,
  input  logic               is_deleted,
  input  logic               end_of_scan,
  input  logic               rec_full,
  output logic               rec_push,
  output rec_t               rec
);
  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_SQ1  = 4'd1;
  localparam logic [3:0] F_SQ2  = 4'd2;
  localparam logic [3:0] F_ADD  = 4'd3;
  localparam logic [3:0] F_COSM = 4'd4;
  localparam logic [3:0] F_DZ   = 4'd5;
  localparam logic [3:0] F_DIV  = 4'd6;
  localparam logic [3:0] F_OFS  = 4'd7;
  localparam logic [3:0] F_PUSH = 4'd8;

  logic [3:0]         state;
  logic [31:0]        xr;
  logic [31:0]        mag;
  logic               neg;
  logic [31:0]        scan_pos;
  logic [31:0]        pos;
  logic [63:0]        id;
  logic               del;
  logic               last;
  logic [63:0]        prod;
  logic signed [81:0] acc;
  logic [79:0]        ofs;
  logic [63:0]        rem;
  logic [6:0]         step;

  logic [31:0]        ipu;
  logic [31:0]        mag_in;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [64:0]        rem_sh;
  logic               rem_ge;
  logic signed [81:0] ofs_s;

  assign ipu    = est_inner_product;
  assign mag_in = ipu[31] ? (~ipu + 32'd1) : ipu;
  assign mul_a  = (state == F_SQ2) ? cfg.query_norm : xr;
  assign mul_b  = (state == F_SQ1) ? xr : cfg.query_norm;
  assign mul_p  = mul_a * mul_b;
  assign rem_sh = {rem, ofs[79]};
  assign rem_ge = rem_sh >= {1'b0, prod};
  assign ofs_s  = $signed({2'b00, ofs});

  assign full         = (state != F_IDLE);
  assign rec_push     = (state == F_PUSH) && !rec_full;
  assign rec.distance = sat64(acc);
  assign rec.pos      = pos;
  assign rec.id       = id;
  assign rec.del      = del;
  assign rec.last     = last;

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        xr   <= vector_norm;
        mag  <= mag_in;
        neg  <= ipu[31];
        pos  <= scan_pos;
        id   <= vector_id;
        del  <= is_deleted;
        last <= end_of_scan;
        acc  <= '0;
        if (cfg.metric == MET_L2) begin
          ofs <= {31'd0, mag_in, 17'd0};
        end else begin
          ofs <= {32'd0, mag_in, 16'd0};
        end
      end
      F_SQ1: begin
        prod <= mul_p;
      end
      F_SQ2: begin
        prod <= mul_p;
        acc  <= $signed({18'd0, prod});
      end
      F_ADD: begin
        acc <= acc + $signed({18'd0, prod});
      end
      F_COSM: begin
        prod <= mul_p;
      end
      F_DZ: begin
        rem  <= '0;
        step <= 7'd79;
        if (prod == '0) begin
          acc <= $signed({18'd0, ONE_Q32});
          ofs <= '0;
        end else begin
          ofs <= {mag, 48'd0};
        end
      end
      F_DIV: begin
        rem  <= rem_ge ? 64'(rem_sh - {1'b0, prod}) : rem_sh[63:0];
        ofs  <= {ofs[78:0], rem_ge};
        step <= step - 7'd1;
        acc  <= $signed({18'd0, ONE_Q32});
      end
      F_OFS: begin
        acc <= neg ? (acc + ofs_s) : (acc - ofs_s);
      end
      F_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      scan_pos <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            scan_pos <= end_of_scan ? '0 : scan_pos + 32'd1;
            if (is_deleted) begin
              state <= F_PUSH;
            end else if (cfg.metric == MET_L2) begin
              state <= F_SQ1;
            end else if (cfg.metric == MET_COS) begin
              state <= F_COSM;
            end else begin
              state <= F_OFS;
            end
          end
        end
        F_SQ1:  state <= F_SQ2;
        F_SQ2:  state <= F_ADD;
        F_ADD:  state <= F_OFS;
        F_COSM: state <= F_DZ;
        F_DZ:   state <= (prod == '0) ? F_OFS : F_DIV;
        F_DIV: begin
          if (step == '0) begin
            state <= F_OFS;
          end
        end
        F_OFS:  state <= F_PUSH;
        F_PUSH: begin
          if (!rec_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: design/mdts_sel.sv
// Back stage: keeps the k nearest candidates or filters by radius and emits results.
// Depends on mdts_pkg; held entries sit in a small memory scanned one per cycle.
module mdts_sel
  import mdts_pkg::*;
#(
  parameter int K_MAX = 16
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic rec_empty,
  input  rec_t rec,
  output logic rec_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);
  localparam int IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CW = $clog2(K_MAX + 1);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DISP = 3'd1;
  localparam logic [2:0] B_MAX  = 3'd2;
  localparam logic [2:0] B_HIT  = 3'd3;
  localparam logic [2:0] B_END  = 3'd4;
  localparam logic [2:0] B_MIN  = 3'd5;
  localparam logic [2:0] B_EMIT = 3'd6;

  typedef struct packed {
    logic signed [63:0] distance;
    logic [31:0]        pos;
    logic [63:0]        id;
  } entry_t;

  entry_t         mem [K_MAX];
  entry_t         mem_q;
  logic [2:0]     state;
  rec_t           cur;
  logic [CW-1:0]  count;
  logic [CW-1:0]  nemit;
  logic [CW-1:0]  scan_ptr;
  logic [K_MAX-1:0] emitted;
  logic           rvalid;
  logic [IW-1:0]  ridx;
  logic           have;
  entry_t         best;
  logic [IW-1:0]  best_idx;

  logic [CW-1:0]  k_eff;
  logic           we;
  logic [IW-1:0]  waddr;
  entry_t         wdata;
  logic           take;
  logic           scan_done;
  logic           res_valid;
  logic           emit_last;

  always_comb begin
    if (cfg.k_limit == '0) begin
      k_eff = CW'(1);
    end else if ({27'd0, cfg.k_limit} > 32'(K_MAX)) begin
      k_eff = CW'(K_MAX);
    end else begin
      k_eff = CW'(cfg.k_limit);
    end
  end

  assign scan_done = (scan_ptr == count) && !rvalid;
  assign emit_last = (nemit + CW'(1)) == count;
  assign rec_pop   = (state == B_IDLE) && !rec_empty;

  always_comb begin
    if (!rvalid) begin
      take = 1'b0;
    end else if (state == B_MAX) begin
      take = !have || pair_lt(best.distance, best.pos, mem_q.distance, mem_q.pos);
    end else begin
      take = !emitted[ridx] &&
             (!have || pair_lt(mem_q.distance, mem_q.pos, best.distance, best.pos));
    end
  end

  always_comb begin
    wdata.distance = cur.distance;
    wdata.pos      = cur.pos;
    wdata.id       = cur.id;
    we    = 1'b0;
    waddr = count[IW-1:0];
    if (state == B_DISP && !cur.del && !cfg.search_mode && count < k_eff) begin
      we = 1'b1;
    end else if (state == B_MAX && scan_done && cur.distance < best.distance) begin
      we    = 1'b1;
      waddr = best_idx;
    end
  end

  always_comb begin
    res       = '0;
    res.done  = 1'b1;
    res_valid = 1'b0;
    case (state)
      B_HIT: begin
        res_valid    = 1'b1;
        res.found    = 1'b1;
        res.id       = cur.id;
        res.distance = cur.distance;
        res.done     = cur.last;
      end
      B_END: begin
        res_valid = cur.last && (cfg.search_mode || count == '0);
      end
      B_EMIT: begin
        res_valid    = 1'b1;
        res.found    = 1'b1;
        res.id       = best.id;
        res.distance = best.distance;
        res.done     = emit_last;
      end
      default: begin
      end
    endcase
  end

  assign res_push = res_valid && !res_full;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[scan_ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      cur <= rec;
    end
    if (state == B_MAX || state == B_MIN) begin
      if (take) begin
        have     <= 1'b1;
        best     <= mem_q;
        best_idx <= ridx;
      end
      ridx <= scan_ptr[IW-1:0];
    end else begin
      have <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      count    <= '0;
      nemit    <= '0;
      scan_ptr <= '0;
      rvalid   <= 1'b0;
      emitted  <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!rec_empty) begin
            state <= B_DISP;
          end
        end
        B_DISP: begin
          scan_ptr <= '0;
          rvalid   <= 1'b0;
          if (cur.del) begin
            state <= B_END;
          end else if (cfg.search_mode) begin
            state <= (cur.distance > cfg.radius) ? B_END : B_HIT;
          end else if (count < k_eff) begin
            count <= count + CW'(1);
            state <= B_END;
          end else begin
            state <= B_MAX;
          end
        end
        B_MAX, B_MIN: begin
          if (scan_ptr < count) begin
            scan_ptr <= scan_ptr + CW'(1);
            rvalid   <= 1'b1;
          end else begin
            rvalid <= 1'b0;
          end
          if (scan_done) begin
            state <= (state == B_MAX) ? B_END : B_EMIT;
          end
        end
        B_HIT: begin
          if (!res_full) begin
            if (cur.last) begin
              count <= '0;
            end
            state <= B_IDLE;
          end
        end
        B_END: begin
          scan_ptr <= '0;
          rvalid   <= 1'b0;
          if (!cur.last) begin
            state <= B_IDLE;
          end else if (!cfg.search_mode && count != '0) begin
            emitted <= '0;
            nemit   <= '0;
            state   <= B_MIN;
          end else if (!res_full) begin
            count <= '0;
            state <= B_IDLE;
          end
        end
        B_EMIT: begin
          scan_ptr <= '0;
          rvalid   <= 1'b0;
          if (!res_full) begin
            emitted[best_idx] <= 1'b1;
            nemit             <= nemit + CW'(1);
            if (emit_last) begin
              count <= '0;
              state <= B_IDLE;
            end else begin
              state <= B_MIN;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: design/mdts_check.sv
// Port-level checker for the top-k selection unit, bound to the top level.
// Depends on metric_distance_topk_select_unit_assert.svh.
`include "metric_distance_topk_select_unit_assert.svh"

module mdts_check (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic               found,
  input logic [63:0]        hit_id,
  input logic signed [63:0] hit_distance,
  input logic               query_done
);

  `MDTS_ASSERT_NEXT(a_busy_after_accept, clk, rst, push && !full, full)
  `MDTS_ASSERT_NOW(a_term_done, clk, rst, !empty && !found, query_done)
  `MDTS_ASSERT_NOW(a_term_zero, clk, rst, !empty && !found, hit_id == '0 && hit_distance == '0)
  `MDTS_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(hit_id))

endmodule

bind metric_distance_topk_select_unit mdts_check u_check (.*);

FILE: test/tb_metric_distance_topk_select_unit.sv
// Testbench for the top-k / range selection unit: directed and random candidate
// scans under every metric and mode, checked item by item against a built-in predictor.
// Depends on mdts_pkg and metric_distance_topk_select_unit.
module tb_metric_distance_topk_select_unit
  import mdts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KCAP = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE = 400;
  localparam logic signed [63:0] DMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] DMIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [31:0] ip;
    logic [31:0] nrm;
    logic [63:0] id;
    logic        del;
    logic        last;
  } cand_t;

  logic               clk;
  logic               rst;
  logic               wr_en;
  logic [2:0]         wr_index;
  logic [63:0]        wr_data;
  logic               push;
  logic               full;
  logic signed [31:0] est_inner_product;
  logic [31:0]        vector_norm;
  logic [63:0]        vector_id;
  logic               is_deleted;
  logic               end_of_scan;
  logic               empty;
  logic               pop;
  logic               found;
  logic [63:0]        hit_id;
  logic signed [63:0] hit_distance;
  logic               query_done;

  metric_distance_topk_select_unit u_dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .push(push), .full(full), .est_inner_product(est_inner_product),
    .vector_norm(vector_norm), .vector_id(vector_id), .is_deleted(is_deleted),
    .end_of_scan(end_of_scan), .empty(empty), .pop(pop), .found(found),
    .hit_id(hit_id), .hit_distance(hit_distance), .query_done(query_done)
  );

  // predictor state
  logic [1:0]         cur_metric;
  logic               cur_mode;
  logic [4:0]         cur_k;
  logic [31:0]        cur_qnorm;
  logic signed [63:0] cur_radius;
  logic signed [63:0] held_dist[KCAP];
  logic [31:0]        held_pos[KCAP];
  logic [63:0]        held_id[KCAP];
  int                 held_count;
  logic [31:0]        scan_pos;

  cand_t pending_items[$];
  res_t  expected_hits[$];
  int    posted;
  int    accepted;
  int    mismatches;
  int    cycles;
  int    drv_idle_pct;
  int    rcv_idle_pct;
  int    hold_req;
  int    hold_seen;
  int    hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [63:0] clamp64(input logic signed [131:0] v);
    if (v > 132'sh7FFF_FFFF_FFFF_FFFF) return DMAX;
    if (v < -132'sh8000_0000_0000_0000) return DMIN;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] metric_distance(input logic [31:0] ip,
                                                          input logic [31:0] nrm);
    logic               neg;
    logic [32:0]        mag;
    logic signed [131:0] acc;
    logic [127:0]       den;
    logic [127:0]       quo;
    neg = ip[31];
    mag = neg ? 33'h1_0000_0000 - {1'b0, ip} : {1'b0, ip};
    case (cur_metric)
      MET_L2: begin
        acc = 132'(nrm) * 132'(nrm) + 132'(cur_qnorm) * 132'(cur_qnorm);
        acc = neg ? acc + (132'(mag) << 17) : acc - (132'(mag) << 17);
      end
      MET_COS: begin
        den = 128'(nrm) * 128'(cur_qnorm);
        if (den == 0) begin
          acc = 132'h1_0000_0000;
        end else begin
          quo = (128'(mag) << 48) / den;
          acc = neg ? 132'h1_0000_0000 + 132'(quo) : 132'h1_0000_0000 - 132'(quo);
        end
      end
      default: begin
        acc = neg ? (132'(mag) << 16) : 132'd0 - (132'(mag) << 16);
      end
    endcase
    return clamp64(acc);
  endfunction

  function automatic logic ranks_below(input logic signed [63:0] da, input logic [31:0] pa,
                                       input logic signed [63:0] db, input logic [31:0] pb);
    if (da != db) return da < db;
    return pa < pb;
  endfunction

  task automatic expect_hit(input logic f, input logic [63:0] id,
                            input logic signed [63:0] d, input logic done);
    res_t r;
    r.found    = f;
    r.id       = id;
    r.distance = d;
    r.done     = done;
    expected_hits.insert(expected_hits.size(), r);
  endtask

  task automatic predict_candidate(input cand_t c);
    logic signed [63:0] d;
    logic signed [63:0] td;
    logic [31:0]        tp;
    logic [63:0]        ti;
    logic [31:0]        pos;
    int                 k;
    int                 mx;
    int                 mn;
    int                 n;
    k = cur_k;
    if (k < 1) k = 1;
    if (k > KCAP) k = KCAP;
    n = 0;
    pos = scan_pos;
    scan_pos = scan_pos + 1;
    if (!c.del) begin
      d = metric_distance(c.ip, c.nrm);
      if (cur_mode) begin
        if (d <= cur_radius) begin
          expect_hit(1'b1, c.id, d, c.last);
          n++;
        end
      end else if (held_count < k) begin
        held_dist[held_count] = d;
        held_pos[held_count] = pos;
        held_id[held_count] = c.id;
        held_count++;
      end else if (held_count > 0) begin
        mx = 0;
        for (int i = 1; i < held_count; i++) begin
          if (ranks_below(held_dist[mx], held_pos[mx], held_dist[i], held_pos[i])) mx = i;
        end
        if (d < held_dist[mx]) begin
          held_dist[mx] = d;
          held_pos[mx] = pos;
          held_id[mx] = c.id;
        end
      end
    end
    if (c.last) begin
      if (!cur_mode) begin
        for (int i = 0; i < held_count; i++) begin
          mn = i;
          for (int j = i + 1; j < held_count; j++) begin
            if (ranks_below(held_dist[j], held_pos[j], held_dist[mn], held_pos[mn])) mn = j;
          end
          if (mn != i) begin
            td = held_dist[i];
            tp = held_pos[i];
            ti = held_id[i];
            held_dist[i] = held_dist[mn];
            held_pos[i] = held_pos[mn];
            held_id[i] = held_id[mn];
            held_dist[mn] = td;
            held_pos[mn] = tp;
            held_id[mn] = ti;
          end
          expect_hit(1'b1, held_id[i], held_dist[i], i + 1 == held_count);
          n++;
        end
      end
      if (n == 0) expect_hit(1'b0, 64'd0, 64'sd0, 1'b1);
      held_count = 0;
      scan_pos = 0;
    end
  endtask

  // sender
  always @(posedge clk) begin
    cand_t c;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_candidate(pending_items.pop_front());
        accepted++;
      end
      if (!(push && full)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= drv_idle_pct) begin
          c = pending_items[0];
          push <= 1'b1;
          est_inner_product <= c.ip;
          vector_norm <= c.nrm;
          vector_id <= c.id;
          is_deleted <= c.del;
          end_of_scan <= c.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: id %h dist %h", hit_id, hit_distance);
        end else begin
          e = expected_hits.pop_front();
          if (found !== e.found || hit_id !== e.id || hit_distance !== e.distance ||
              query_done !== e.done) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp found %b id %h dist %h done %b", e.found, e.id,
                       e.distance, e.done);
              $display("          got found %b id %h dist %h done %b", found, hit_id,
                       hit_distance, query_done);
            end
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= $urandom_range(99) >= rcv_idle_pct;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk); while (!(accepted == posted && expected_hits.size() == 0));
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_METRIC: cur_metric = val[1:0];
      REG_MODE:   cur_mode = val[0];
      REG_K:      cur_k = val[4:0];
      REG_QNORM:  cur_qnorm = val[31:0];
      default:    cur_radius = val;
    endcase
  endtask

  task automatic set_cfg(input logic [1:0] m, input logic md, input logic [4:0] k,
                         input logic [31:0] qn, input logic [63:0] rad);
    wait_idle();
    write_reg(REG_METRIC, {62'd0, m});
    write_reg(REG_MODE, {63'd0, md});
    write_reg(REG_K, {59'd0, k});
    write_reg(REG_QNORM, {32'd0, qn});
    write_reg(REG_RADIUS, rad);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic add(input logic [31:0] ip, input logic [31:0] nrm, input logic [63:0] id,
                     input logic del, input logic last);
    cand_t c;
    c.ip = ip;
    c.nrm = nrm;
    c.id = id;
    c.del = del;
    c.last = last;
    pending_items.insert(pending_items.size(), c);
    posted++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return $urandom_range(0, 32'h0000_4000);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic rand_scan(input int n);
    for (int i = 0; i < n; i++) begin
      add(rand_word(), rand_word(), {$urandom, $urandom}, $urandom_range(9) == 0, i == n - 1);
    end
  endtask

  task automatic rand_cfg();
    logic [63:0] rad;
    logic [4:0]  k;
    case ($urandom_range(3))
      0: rad = {$urandom, $urandom};
      1: rad = $urandom_range(1) ? DMAX : DMIN;
      default: rad = {{30{1'b0}}, 34'($urandom)};
    endcase
    k = $urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(1, 8));
    set_cfg(2'($urandom), 1'($urandom), k, rand_word(), rad);
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_METRIC;
    wr_data = 64'd0;
    push = 1'b0;
    pop = 1'b0;
    est_inner_product = 32'sd0;
    vector_norm = 32'd0;
    vector_id = 64'd0;
    is_deleted = 1'b0;
    end_of_scan = 1'b0;
    cur_metric = MET_L2;
    cur_mode = 1'b0;
    cur_k = 5'd1;
    cur_qnorm = 32'd0;
    cur_radius = 64'sd0;
    held_count = 0;
    scan_pos = 32'd0;
    posted = 0;
    accepted = 0;
    mismatches = 0;
    cycles = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    drv_idle_pct = 28;
    rcv_idle_pct = 46;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_cfg(MET_L2, 1'b0, 5'd3, 32'h0001_0000, 64'd0);
    add(32'h7FFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    add(32'h8000_0000, 32'hFFFF_FFFF, 64'h1, 1'b0, 1'b0);
    add(32'h0001_0000, 32'h0001_0000, 64'h2, 1'b0, 1'b0);
    add(32'h0001_0000, 32'h0001_0000, 64'h3, 1'b0, 1'b0);
    add(32'h8000_0000, 32'd0, 64'h4, 1'b0, 1'b0);
    add(32'd0, 32'd0, 64'h5, 1'b1, 1'b1);
    set_cfg(MET_IP, 1'b0, 5'd0, 32'hFFFF_FFFF, 64'd0);
    add(32'h7FFF_FFFF, 32'd0, 64'h10, 1'b0, 1'b0);
    add(32'h8000_0000, 32'd0, 64'h11, 1'b0, 1'b1);
    set_cfg(MET_COS, 1'b1, 5'd31, 32'd1, DMAX);
    add(32'h7FFF_FFFF, 32'd1, 64'h20, 1'b0, 1'b0);
    add(32'h8000_0000, 32'd1, 64'h21, 1'b0, 1'b0);
    add(32'h0000_8000, 32'd0, 64'h22, 1'b0, 1'b1);
    set_cfg(2'd3, 1'b1, 5'd5, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add(32'h0000_0001, 32'd7, 64'h30, 1'b0, 1'b0);
    add(32'h8000_0000, 32'd7, 64'h31, 1'b1, 1'b1);
    set_cfg(MET_L2, 1'b0, 5'd4, 32'h0002_0000, DMIN);
    for (int i = 0; i < 4; i++) add(32'h0000_1000 * i, 32'h0001_0000, 64'h40 + i, 1'b0, 1'b0);
    set_cfg(MET_L2, 1'b0, 5'd2, 32'h0002_0000, DMIN);
    add(32'h0004_0000, 32'h0001_0000, 64'h48, 1'b0, 1'b0);
    add(32'h0000_0000, 32'h0000_0000, 64'h49, 1'b0, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      drv_idle_pct = ph == 0 ? 28 : ph == 1 ? 46 : 0;
      rcv_idle_pct = ph == 0 ? 46 : ph == 1 ? 28 : 0;
      for (int j = 0; j < 3; j++) begin
        rand_cfg();
        rand_scan($urandom_range(1, 6));
        rand_scan($urandom_range(1, 6));
      end
    end

    set_cfg(MET_IP, 1'b1, 5'd16, 32'h0001_0000, DMAX);
    hold_req++;
    rand_scan(30);
    set_cfg(MET_L2, 1'b0, 5'd16, 32'h0000_8000, 64'd0);
    rand_scan(10);

    wait_idle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/mdts_pkg.sv
design/mdts_fifo.sv
design/mdts_dist.sv
design/mdts_sel.sv
design/metric_distance_topk_select_unit.sv
design/mdts_check.sv
test/tb_metric_distance_topk_select_unit.sv
